/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the find-and-replace block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lfr_pkg.sv */
// ----------------------------------------------------------------------------
// lfr_pkg
// Types, constants and byte helpers for the literal find-and-replace stream.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

  localparam int TOTAL_W     = 24;
  localparam int LIMIT_W     = 25;
  localparam int SUM_W       = LIMIT_W + 1;
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] UNDERSCORE = 8'h5F;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;

  typedef logic [7:0][7:0] byte_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_TEXT        = 4'd0,
    CFG_SEARCH_LENGTH      = 4'd1,
    CFG_REPLACEMENT_TEXT   = 4'd2,
    CFG_REPLACEMENT_LENGTH = 4'd3,
    CFG_MATCH_CASE         = 4'd4,
    CFG_WHOLE_WORDS_ONLY   = 4'd5,
    CFG_REGEX_MODE         = 4'd6,
    CFG_OUTPUT_LIMIT       = 4'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CAPACITY = 2'd1,
    STATUS_NO_REGEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_REPL,
    KIND_SUMMARY
  } kind_t;

  typedef struct packed {
    byte_vec_t          search_text;
    logic [LEN_W-1:0]   search_len;
    byte_vec_t          repl_text;
    logic [LEN_W-1:0]   repl_len;
    logic               match_case;
    logic               whole_words;
    logic               regex;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data;
    logic               last;
    logic [TOTAL_W-1:0] match_total;
    logic [TOTAL_W-1:0] replaced_total;
    status_t            status;
  } entry_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
    if (!exact && (c inside {[8'h41:8'h5A]})) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || (c == UNDERSCORE);
  endfunction

endpackage

`default_nettype wire

/* rtl/lfr_in_if.sv */
// ----------------------------------------------------------------------------
// lfr_in_if
// Text input channel: one byte, a presence flag and an end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfr_in_if import lfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, output text_byte, output byte_present,
                  output end_of_text, input ready);
  modport sink (input valid, input text_byte, input byte_present,
                input end_of_text, output ready);
endinterface

`default_nettype wire

/* rtl/lfr_out_if.sv */
// ----------------------------------------------------------------------------
// lfr_out_if
// Result channel: output bytes and the closing summary of a text.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfr_out_if import lfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [7:0]         out_byte;
  logic               out_byte_valid;
  logic               run_last;
  logic               summary_valid;
  logic [TOTAL_W-1:0] match_total;
  logic [TOTAL_W-1:0] replaced_total;
  status_t            status;

  modport source (output valid, output out_byte, output out_byte_valid,
                  output run_last, output summary_valid, output match_total,
                  output replaced_total, output status, input ready);
  modport sink (input valid, input out_byte, input out_byte_valid,
                input run_last, input summary_valid, input match_total,
                input replaced_total, input status, output ready);
endinterface

`default_nettype wire

/* rtl/lfr_front.sv */
// ----------------------------------------------------------------------------
// lfr_front
// Takes text bytes, keeps the undecided window and decides one position per
// cycle unless full, queuing copy, replace and summary work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfr_front import lfr_pkg::*; #(
  parameter int SEARCH_MAX  = 8,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  lfr_in_if.sink      text_in,
  input  wire logic   full,
  output logic        push,
  output entry_t      push_entry,
  output logic        text_open
);

  localparam int WIN    = SEARCH_MAX + 1;
  localparam int FILL_W = $clog2(WIN + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic {RUN, FLUSH} state_t;

  state_t                  state, state_next;
  logic [7:0]              window [WIN];
  logic [7:0]              window_next [WIN];
  logic [FILL_W-1:0]       fill, fill_next;
  logic [7:0]              prior_byte, prior_byte_next;
  logic                    prior_valid, prior_valid_next;
  logic [LIMIT_W-1:0]      emitted, emitted_next;
  logic [COUNT_WIDTH-1:0]  match_count, match_count_next;
  logic [COUNT_WIDTH-1:0]  replace_count, replace_count_next;
  logic                    overflowed, overflowed_next;

  logic [7:0]              w_cur [WIN];
  logic [FILL_W-1:0]       f_cur;
  logic [FILL_W-1:0]       len_f;
  logic [FILL_W-1:0]       shift;
  logic                    accept, append, decide, summary_go;
  logic                    all_eq, hit, room_repl, room_byte;
  logic [7:0]              tail_byte, last_pat;

  assign len_f     = FILL_W'(cfg.search_len);
  assign text_open = (fill != '0) || prior_valid;
  assign room_repl = ({1'b0, emitted} + SUM_W'(cfg.repl_len)) < {1'b0, cfg.output_limit};
  assign room_byte = ({1'b0, emitted} + SUM_W'(1)) < {1'b0, cfg.output_limit};

  always_comb begin
    text_in.ready = (state == RUN) && !full;
    accept = text_in.valid && text_in.ready;
    append = accept && text_in.byte_present && !cfg.regex;

    w_cur = window;
    f_cur = fill;
    if (append) begin
      for (int i = 0; i < WIN; i++) begin
        if (FILL_W'(i) == fill) begin
          w_cur[i] = text_in.text_byte;
        end
      end
      f_cur = fill + 1'b1;
    end

    decide = append ? (f_cur > len_f)
                    : ((state == FLUSH) && !full && !cfg.regex && (fill != '0));
    summary_go = (state == FLUSH) && !full && (cfg.regex || (fill == '0));

    all_eq    = 1'b1;
    tail_byte = '0;
    last_pat  = w_cur[0];
    for (int i = 0; i < SEARCH_MAX; i++) begin
      if ((LEN_W'(i) < cfg.search_len) &&
          (fold_byte(w_cur[i], cfg.match_case) !=
           fold_byte(cfg.search_text[i], cfg.match_case))) begin
        all_eq = 1'b0;
      end
      if (LEN_W'(i + 1) == cfg.search_len) begin
        last_pat = w_cur[i];
      end
    end
    for (int i = 0; i < WIN; i++) begin
      if (LEN_W'(i) == cfg.search_len) begin
        tail_byte = w_cur[i];
      end
    end
    hit = (f_cur >= len_f) && all_eq;
    if (hit && cfg.whole_words) begin
      if (prior_valid && is_word(prior_byte)) begin
        hit = 1'b0;
      end
      if ((f_cur > len_f) && is_word(tail_byte)) begin
        hit = 1'b0;
      end
    end

    state_next         = state;
    fill_next          = f_cur;
    prior_byte_next    = prior_byte;
    prior_valid_next   = prior_valid;
    emitted_next       = emitted;
    match_count_next   = match_count;
    replace_count_next = replace_count;
    overflowed_next    = overflowed;
    shift              = '0;

    push                      = 1'b0;
    push_entry.kind           = KIND_BYTE;
    push_entry.data           = w_cur[0];
    push_entry.last           = (state == RUN) && !text_in.end_of_text;
    push_entry.match_total    = '0;
    push_entry.replaced_total = '0;
    push_entry.status         = STATUS_OK;

    if (decide) begin
      prior_valid_next = 1'b1;
      if (hit) begin
        shift           = len_f;
        prior_byte_next = last_pat;
        if (match_count != COUNT_MAX) begin
          match_count_next = match_count + 1'b1;
        end
        if (!overflowed) begin
          if (!room_repl) begin
            overflowed_next = 1'b1;
          end else begin
            emitted_next = emitted + LIMIT_W'(cfg.repl_len);
            if (replace_count != COUNT_MAX) begin
              replace_count_next = replace_count + 1'b1;
            end
            if (cfg.repl_len != '0) begin
              push            = 1'b1;
              push_entry.kind = KIND_REPL;
            end
          end
        end
      end else begin
        shift           = FILL_W'(1);
        prior_byte_next = w_cur[0];
        if (!overflowed) begin
          if (!room_byte) begin
            overflowed_next = 1'b1;
          end else begin
            emitted_next = emitted + 1'b1;
            push         = 1'b1;
          end
        end
      end
      fill_next = f_cur - shift;
    end

    for (int i = 0; i < WIN; i++) begin
      window_next[i] = w_cur[i];
      for (int s = 1; s <= SEARCH_MAX; s++) begin
        if ((shift == FILL_W'(s)) && (i + s < WIN)) begin
          window_next[i] = w_cur[i + s];
        end
      end
    end

    if (summary_go) begin
      push            = 1'b1;
      push_entry.kind = KIND_SUMMARY;
      push_entry.data = '0;
      push_entry.last = 1'b1;
      if (cfg.regex) begin
        push_entry.status = STATUS_NO_REGEX;
      end else begin
        push_entry.match_total    = TOTAL_W'(match_count);
        push_entry.replaced_total = TOTAL_W'(replace_count);
        push_entry.status         = overflowed ? STATUS_CAPACITY : STATUS_OK;
      end
      state_next         = RUN;
      fill_next          = '0;
      prior_byte_next    = '0;
      prior_valid_next   = 1'b0;
      emitted_next       = '0;
      match_count_next   = '0;
      replace_count_next = '0;
      overflowed_next    = 1'b0;
    end

    if (accept && text_in.end_of_text) begin
      state_next = FLUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= RUN;
      fill          <= '0;
      prior_byte    <= '0;
      prior_valid   <= 1'b0;
      emitted       <= '0;
      match_count   <= '0;
      replace_count <= '0;
      overflowed    <= 1'b0;
    end else begin
      state         <= state_next;
      fill          <= fill_next;
      prior_byte    <= prior_byte_next;
      prior_valid   <= prior_valid_next;
      emitted       <= emitted_next;
      match_count   <= match_count_next;
      replace_count <= replace_count_next;
      overflowed    <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
  end

  `ASSERT_IMPLY(a_fill_bound, clk, rst, state == RUN, fill <= len_f, "window fill exceeds pattern length")
  `ASSERT_NEXT(a_summary_clears, clk, rst, push && (push_entry.kind == KIND_SUMMARY), (fill == '0) && !prior_valid && (state == RUN), "text state not cleared after summary")

endmodule

`default_nettype wire

/* rtl/lfr_queue.sv */
// ----------------------------------------------------------------------------
// lfr_queue
// Short work queue between the deciding front end and the emitting back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfr_queue import lfr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `ASSERT_IMPLY(a_push_room, clk, rst, push, !full, "work queued while the queue is full")
  `ASSERT_IMPLY(a_pop_data, clk, rst, pop, !empty, "work taken from an empty queue")

endmodule

`default_nettype wire

/* rtl/lfr_back.sv */
// ----------------------------------------------------------------------------
// lfr_back
// Expands queued work into result items: copied bytes, replacement bytes one
// per cycle while text_out is not stalled, and the summary, through a
// registered output stage.
`default_nettype none
`include "assert_macros.svh"

module lfr_back import lfr_pkg::*; #(
  parameter int REPLACE_MAX = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire entry_t head,
  input  wire logic   empty,
  output logic        pop,
  lfr_out_if.source   text_out
);

  localparam int POS_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  logic [POS_W-1:0] pos;
  logic             load, repl_final;

  assign load       = !empty && (!text_out.valid || text_out.ready);
  assign repl_final = (LEN_W'(pos) + LEN_W'(1)) == cfg.repl_len;
  assign pop        = load && ((head.kind != KIND_REPL) || repl_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_out.valid <= 1'b0;
      pos            <= '0;
    end else if (load) begin
      text_out.valid <= 1'b1;
      if (head.kind == KIND_REPL) begin
        pos <= repl_final ? '0 : pos + 1'b1;
      end
    end else if (text_out.ready) begin
      text_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text_out.out_byte       <= '0;
      text_out.out_byte_valid <= 1'b0;
      text_out.run_last       <= head.last;
      text_out.summary_valid  <= 1'b0;
      text_out.match_total    <= '0;
      text_out.replaced_total <= '0;
      text_out.status         <= STATUS_OK;
      case (head.kind)
        KIND_BYTE: begin
          text_out.out_byte       <= head.data;
          text_out.out_byte_valid <= 1'b1;
        end
        KIND_REPL: begin
          text_out.out_byte       <= cfg.repl_text[pos];
          text_out.out_byte_valid <= 1'b1;
          text_out.run_last       <= head.last && repl_final;
        end
        KIND_SUMMARY: begin
          text_out.summary_valid  <= 1'b1;
          text_out.match_total    <= head.match_total;
          text_out.replaced_total <= head.replaced_total;
          text_out.status         <= head.status;
        end
        default: begin
          text_out.out_byte_valid <= 1'b0;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_repl_pos, clk, rst, !empty && (head.kind == KIND_REPL), LEN_W'(pos) < cfg.repl_len, "replacement position past replacement length")

endmodule

`default_nettype wire

/* rtl/literal_find_replace_stream.sv */
// ----------------------------------------------------------------------------
// literal_find_replace_stream
// Streaming literal find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
// Text enters on text_in, one request per byte; byte_present marks a real
// byte and end_of_text closes the text. Results leave on text_out: rewritten
// bytes, then one summary with match and replacement counts and a status.
// The user writes registers through cfg_write, cfg_index and cfg_data while
// the block is idle; the block does not enforce this, but a new search
// length is refused while a text is open. A byte is taken every cycle while
// the four-entry work queue has room and the block is not flushing. It is
// decided once the window holds one byte more than the pattern; its result
// reaches text_out via the work queue and the registered output stage. A
// match with an r-byte replacement yields r one-byte items. At end of text
// each undecided byte is decided in turn, then the summary is queued, and
// no input is taken meanwhile. Reset clears the text state and the queue
// and loads the register defaults. When the receiver holds text_out.ready
// low the output register keeps its result and the queue absorbs further
// work until it fills, then text_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_find_replace_stream import lfr_pkg::*; #(
  parameter int SEARCH_MAX  = 8,
  parameter int REPLACE_MAX = 8,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lfr_in_if.sink                     text_in,
  lfr_out_if.source                  text_out,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [63:0]        search_text;
  logic [LEN_W-1:0]   pattern_length;
  logic [63:0]        replacement_text;
  logic [LEN_W-1:0]   substitute_length;
  logic               match_case;
  logic               whole_words_only;
  logic               regex_mode;
  logic [LIMIT_W-1:0] output_limit;

  cfg_t   cfg;
  entry_t push_entry, head;
  logic   push, pop, empty, full, text_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_text       <= '0;
      pattern_length    <= LEN_W'(1);
      replacement_text  <= '0;
      substitute_length <= '0;
      match_case        <= 1'b0;
      whole_words_only  <= 1'b0;
      regex_mode        <= 1'b0;
      output_limit      <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEARCH_TEXT:        search_text <= cfg_data;
        CFG_SEARCH_LENGTH: begin
          if (!text_open) begin
            pattern_length <= cfg_data[LEN_W-1:0];
          end
        end
        CFG_REPLACEMENT_TEXT:   replacement_text <= cfg_data;
        CFG_REPLACEMENT_LENGTH: substitute_length <= cfg_data[LEN_W-1:0];
        CFG_MATCH_CASE:         match_case <= cfg_data[0];
        CFG_WHOLE_WORDS_ONLY:   whole_words_only <= cfg_data[0];
        CFG_REGEX_MODE:         regex_mode <= cfg_data[0];
        CFG_OUTPUT_LIMIT:       output_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.search_text = search_text;
    if (pattern_length == '0) begin
      cfg.search_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(SEARCH_MAX)) begin
      cfg.search_len = LEN_W'(SEARCH_MAX);
    end else begin
      cfg.search_len = pattern_length;
    end
    cfg.repl_text = replacement_text;
    if (substitute_length > LEN_W'(REPLACE_MAX)) begin
      cfg.repl_len = LEN_W'(REPLACE_MAX);
    end else begin
      cfg.repl_len = substitute_length;
    end
    cfg.match_case   = match_case;
    cfg.whole_words  = whole_words_only;
    cfg.regex        = regex_mode;
    cfg.output_limit = output_limit;
  end

  lfr_front #(
    .SEARCH_MAX  (SEARCH_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .text_in    (text_in),
    .full       (full),
    .push       (push),
    .push_entry (push_entry),
    .text_open  (text_open)
  );

  lfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  lfr_back #(
    .REPLACE_MAX (REPLACE_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .text_out (text_out)
  );

endmodule

`default_nettype wire

/* test/literal_find_replace_stream_test.sv */
// ----------------------------------------------------------------------------
// literal_find_replace_stream_test
// Self-checking bench for the streaming literal find-and-replace block.
// ----------------------------------------------------------------------------
// A behavioral copy of the block, kept in this module, predicts every output
// request from each accepted input request. A checker compares each output
// request field by field with the oldest prediction. Directed cases cover
// the defaults, case folding, word bounds, the capacity stop, the regex
// request, length clamping and the length lock while a text is open. Random
// texts follow, from a small alphabet with embedded copies of the pattern,
// under random register settings; from text five both sides stall randomly.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_find_replace_stream_test;
  import lfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEARCH_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int unsigned COUNT_MAX = (1 << 24) - 1;
  localparam int RANDOM_ITEMS = 220;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 12;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_PAST_LAST = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP = 4'd15;
  localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES = '1;

  typedef struct {
    logic [7:0] out_byte;
    logic out_byte_valid;
    logic run_last;
    logic summary_valid;
    logic [TOTAL_W-1:0] match_total;
    logic [TOTAL_W-1:0] replaced_total;
    status_t status;
  } text_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lfr_in_if text_in_bus ();
  lfr_out_if text_out_bus ();

  literal_find_replace_stream DUT (
    .clk(clk),
    .rst(rst),
    .text_in(text_in_bus),
    .text_out(text_out_bus),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [63:0] pattern_text;
  logic [63:0] repl_text;
  logic [3:0] pattern_len_reg;
  logic [3:0] repl_len_reg;
  logic exact_case;
  logic whole_words;
  logic regex_on;
  logic [LIMIT_W-1:0] out_limit;

  logic [7:0] window_bytes [SEARCH_MAX+1];
  int unsigned window_fill;
  logic [7:0] prior_byte;
  bit prior_valid;
  int unsigned emitted_bytes;
  int unsigned match_count;
  int unsigned replace_count;
  bit capacity_hit;

  text_result_t predicted_out [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  string alphabet = "abAB_ .1-";

  function automatic int unsigned pattern_len();
    if (pattern_len_reg == 0) return 1;
    if (pattern_len_reg > SEARCH_MAX) return SEARCH_MAX;
    return pattern_len_reg;
  endfunction

  function automatic int unsigned repl_len();
    return (repl_len_reg > REPLACE_MAX) ? REPLACE_MAX : repl_len_reg;
  endfunction

  function automatic logic [7:0] fold_char(logic [7:0] c);
    if (!exact_case && c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_");
  endfunction

  function automatic int unsigned bump(int unsigned v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    text_result_t r;
    r.out_byte = b;
    r.out_byte_valid = 1'b1;
    r.run_last = 1'b0;
    r.summary_valid = 1'b0;
    r.match_total = '0;
    r.replaced_total = '0;
    r.status = STATUS_OK;
    predicted_out.push_back(r);
  endfunction

  function automatic void drop_window(int unsigned k);
    for (int unsigned i = 0; i + k < window_fill; i++) window_bytes[i] = window_bytes[i + k];
    window_fill -= k;
  endfunction

  function automatic void clear_text();
    window_fill = 0;
    prior_byte = 8'h00;
    prior_valid = 1'b0;
    emitted_bytes = 0;
    match_count = 0;
    replace_count = 0;
    capacity_hit = 1'b0;
  endfunction

  function automatic void load_defaults();
    pattern_text = '0;
    pattern_len_reg = 4'd1;
    repl_text = '0;
    repl_len_reg = 4'd0;
    exact_case = 1'b0;
    whole_words = 1'b0;
    regex_on = 1'b0;
    out_limit = LIMIT_RESET;
    clear_text();
  endfunction

  function automatic void decide_oldest();
    int unsigned len;
    int unsigned rlen;
    bit hit;
    len = pattern_len();
    rlen = repl_len();
    hit = 1'b0;
    if (window_fill >= len) begin
      hit = 1'b1;
      for (int unsigned i = 0; i < len; i++) begin
        if (fold_char(window_bytes[i]) != fold_char(pattern_text[8*i +: 8])) hit = 1'b0;
      end
      if (hit && whole_words) begin
        if (prior_valid && word_char(prior_byte)) hit = 1'b0;
        if (window_fill > len && word_char(window_bytes[len])) hit = 1'b0;
      end
    end
    if (hit) begin
      match_count = bump(match_count);
      if (!capacity_hit) begin
        if (emitted_bytes + rlen >= out_limit) begin
          capacity_hit = 1'b1;
        end else begin
          for (int unsigned i = 0; i < rlen; i++) push_byte(repl_text[8*i +: 8]);
          emitted_bytes += rlen;
          replace_count = bump(replace_count);
        end
      end
      prior_byte = window_bytes[len - 1];
      drop_window(len);
    end else begin
      if (!capacity_hit) begin
        if (emitted_bytes + 1 >= out_limit) begin
          capacity_hit = 1'b1;
        end else begin
          push_byte(window_bytes[0]);
          emitted_bytes += 1;
        end
      end
      prior_byte = window_bytes[0];
      drop_window(1);
    end
    prior_valid = 1'b1;
  endfunction

  function automatic void predict_request(logic [7:0] b, logic present, logic last);
    int queued;
    text_result_t r;
    queued = predicted_out.size();
    if (present && !regex_on && window_fill < SEARCH_MAX + 1) begin
      window_bytes[window_fill] = b;
      window_fill++;
      if (window_fill > pattern_len()) decide_oldest();
    end
    if (last) begin
      r.out_byte = 8'h00;
      r.out_byte_valid = 1'b0;
      r.run_last = 1'b0;
      r.summary_valid = 1'b1;
      r.match_total = '0;
      r.replaced_total = '0;
      r.status = STATUS_NO_REGEX;
      if (!regex_on) begin
        while (window_fill > 0) decide_oldest();
        r.match_total = match_count[TOTAL_W-1:0];
        r.replaced_total = replace_count[TOTAL_W-1:0];
        r.status = capacity_hit ? STATUS_CAPACITY : STATUS_OK;
      end
      predicted_out.push_back(r);
      clear_text();
    end
    if (predicted_out.size() > queued) begin
      r = predicted_out.pop_back();
      r.run_last = 1'b1;
      predicted_out.push_back(r);
    end
  endfunction

  function automatic void store_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    case (idx)
      CFG_SEARCH_TEXT: pattern_text = value;
      CFG_SEARCH_LENGTH: begin
        if (window_fill == 0 && !prior_valid) pattern_len_reg = value[3:0];
      end
      CFG_REPLACEMENT_TEXT: repl_text = value;
      CFG_REPLACEMENT_LENGTH: repl_len_reg = value[3:0];
      CFG_MATCH_CASE: exact_case = value[0];
      CFG_WHOLE_WORDS_ONLY: whole_words = value[0];
      CFG_REGEX_MODE: regex_on = value[0];
      CFG_OUTPUT_LIMIT: out_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] pack_text(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(99) < 10) return 8'($urandom_range(255));
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, want);
    mismatch_count++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    store_register(idx, value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(logic [7:0] b, logic present, logic last);
    while (idle_on && $urandom_range(99) < 20) begin
      text_in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    text_in_bus.valid <= 1'b1;
    text_in_bus.text_byte <= b;
    text_in_bus.byte_present <= present;
    text_in_bus.end_of_text <= last;
    do @(posedge clk); while (!text_in_bus.ready);
    predict_request(b, present, last);
  endtask

  task automatic send_string(string s, bit close_text);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b1, close_text && i == s.len() - 1);
  endtask

  task automatic release_input();
    text_in_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (predicted_out.size() != 0) @(posedge clk);
  endtask

  task automatic settle_idle();
    release_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_registers();
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hA5, 1'b0, 1'b0);
    send_request("A", 1'b1, 1'b1);
  endtask

  task automatic test_fold_and_word_bounds();
    settle_idle();
    write_register(CFG_SEARCH_TEXT, pack_text("cat"));
    write_register(CFG_SEARCH_LENGTH, 64'd3);
    write_register(CFG_REPLACEMENT_TEXT, pack_text("dog"));
    write_register(CFG_REPLACEMENT_LENGTH, 64'd3);
    write_register(CFG_MATCH_CASE, 64'd0);
    write_register(CFG_WHOLE_WORDS_ONLY, 64'd1);
    send_string("CAT.cat_", 1'b1);
  endtask

  task automatic test_capacity_stop();
    settle_idle();
    write_register(CFG_SEARCH_TEXT, pack_text("a"));
    write_register(CFG_SEARCH_LENGTH, 64'd1);
    write_register(CFG_REPLACEMENT_TEXT, pack_text("xyz"));
    write_register(CFG_MATCH_CASE, 64'd1);
    write_register(CFG_WHOLE_WORDS_ONLY, 64'd0);
    write_register(CFG_OUTPUT_LIMIT, 64'd4);
    send_string("bAaa", 1'b1);
  endtask

  task automatic test_regex_request();
    settle_idle();
    write_register(CFG_REGEX_MODE, 64'd1);
    send_request("a", 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    settle_idle();
    write_register(CFG_REGEX_MODE, 64'd0);
  endtask

  task automatic test_length_clamps();
    settle_idle();
    write_register(CFG_SEARCH_TEXT, pack_text("x"));
    write_register(CFG_SEARCH_LENGTH, 64'd0);
    write_register(CFG_REPLACEMENT_TEXT, '1);
    write_register(CFG_REPLACEMENT_LENGTH, 64'd15);
    write_register(CFG_MATCH_CASE, 64'd0);
    write_register(CFG_OUTPUT_LIMIT, 64'(LIMIT_ALL_ONES));
    send_request("x", 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    settle_idle();
    write_register(CFG_OUTPUT_LIMIT, 64'd0);
    send_request("z", 1'b1, 1'b1);
  endtask

  task automatic test_length_locked_mid_text();
    settle_idle();
    write_register(CFG_OUTPUT_LIMIT, 64'(LIMIT_RESET));
    write_register(CFG_SEARCH_TEXT, pack_text("ab"));
    write_register(CFG_SEARCH_LENGTH, 64'd2);
    write_register(CFG_REPLACEMENT_TEXT, pack_text("Q"));
    write_register(CFG_REPLACEMENT_LENGTH, 64'd1);
    send_request("a", 1'b1, 1'b0);
    settle_idle();
    write_register(CFG_SEARCH_LENGTH, 64'd1);
    write_register(CFG_PAST_LAST, {$urandom, $urandom});
    write_register(CFG_INDEX_TOP, {$urandom, $urandom});
    send_request("b", 1'b1, 1'b0);
    send_request("c", 1'b1, 1'b1);
  endtask

  task automatic randomize_setup();
    logic [63:0] noise;
    logic [63:0] pat;
    logic [3:0] len;
    int r;
    settle_idle();
    for (int i = 0; i < 8; i++) pat[8*i +: 8] = alphabet[$urandom_range(5)];
    r = $urandom_range(99);
    if (r < 5) len = 4'd0;
    else if (r < 12) len = 4'($urandom_range(15, 9));
    else if (r < 80) len = 4'($urandom_range(1, 3));
    else len = 4'($urandom_range(4, 8));
    write_register(CFG_SEARCH_TEXT, pat);
    noise = {$urandom, $urandom};
    write_register(CFG_SEARCH_LENGTH, {noise[63:4], len});
    write_register(CFG_REPLACEMENT_TEXT, {$urandom, $urandom});
    noise = {$urandom, $urandom};
    len = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(0, 8));
    write_register(CFG_REPLACEMENT_LENGTH, {noise[63:4], len});
    noise = {$urandom, $urandom};
    write_register(CFG_MATCH_CASE, {noise[63:1], 1'($urandom_range(1))});
    noise = {$urandom, $urandom};
    write_register(CFG_WHOLE_WORDS_ONLY, {noise[63:1], 1'($urandom_range(1))});
    noise = {$urandom, $urandom};
    write_register(CFG_REGEX_MODE, {noise[63:1], 1'($urandom_range(99) < 8)});
    noise = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 8) noise[LIMIT_W-1:0] = '0;
    else if (r < 25) noise[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 30));
    else if (r < 30) noise[LIMIT_W-1:0] = LIMIT_ALL_ONES;
    else noise[LIMIT_W-1:0] = LIMIT_RESET;
    write_register(CFG_OUTPUT_LIMIT, noise);
  endtask

  task automatic test_random_texts();
    int random_items;
    int text_count;
    int text_len;
    logic [7:0] c;
    random_items = 0;
    text_count = 0;
    while (random_items < RANDOM_ITEMS) begin
      idle_on = (text_count >= 4);
      randomize_setup();
      text_len = regex_on ? $urandom_range(1, 4) : $urandom_range(3, 22);
      for (int n = 0; n < text_len; n++) begin
        if ($urandom_range(99) < 5) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
        if ($urandom_range(99) < 4) begin
          release_input();
          wait_drained();
        end
        if ($urandom_range(99) < 35) begin
          for (int i = 0; i < pattern_len(); i++) begin
            c = pattern_text[8*i +: 8];
            if (!exact_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                $urandom_range(1)) c = c ^ 8'h20;
            if ($urandom_range(99) < 8) c = random_char();
            send_request(c, 1'b1, 1'b0);
            if (!regex_on) random_items++;
          end
        end else begin
          send_request(random_char(), 1'b1, 1'b0);
          if (!regex_on) random_items++;
        end
      end
      if ($urandom_range(1)) send_request(random_char(), 1'b1, 1'b1);
      else send_request(8'($urandom_range(255)), 1'b0, 1'b1);
      text_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    text_result_t want;
    text_out_bus.ready <= !idle_on || ($urandom_range(99) >= 20);
    if (!rst && text_out_bus.valid && text_out_bus.ready) begin
      if (predicted_out.size() == 0) begin
        report_mismatch("unexpected result", 32'(text_out_bus.out_byte), 32'h0);
      end else begin
        want = predicted_out.pop_front();
        if (text_out_bus.out_byte !== want.out_byte)
          report_mismatch("out_byte", 32'(text_out_bus.out_byte), 32'(want.out_byte));
        if (text_out_bus.out_byte_valid !== want.out_byte_valid)
          report_mismatch("out_byte_valid", 32'(text_out_bus.out_byte_valid),
                          32'(want.out_byte_valid));
        if (text_out_bus.run_last !== want.run_last)
          report_mismatch("run_last", 32'(text_out_bus.run_last), 32'(want.run_last));
        if (text_out_bus.summary_valid !== want.summary_valid)
          report_mismatch("summary_valid", 32'(text_out_bus.summary_valid),
                          32'(want.summary_valid));
        if (text_out_bus.match_total !== want.match_total)
          report_mismatch("match_total", 32'(text_out_bus.match_total),
                          32'(want.match_total));
        if (text_out_bus.replaced_total !== want.replaced_total)
          report_mismatch("replaced_total", 32'(text_out_bus.replaced_total),
                          32'(want.replaced_total));
        if (text_out_bus.status !== want.status)
          report_mismatch("status", 32'(text_out_bus.status), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_in_bus.valid && text_in_bus.ready) ||
        (text_out_bus.valid && text_out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    load_defaults();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    text_in_bus.valid <= 1'b0;
    text_in_bus.text_byte <= 8'h00;
    text_in_bus.byte_present <= 1'b0;
    text_in_bus.end_of_text <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_default_registers();
    test_fold_and_word_bounds();
    test_capacity_stop();
    test_regex_request();
    test_length_clamps();
    test_length_locked_mid_text();
    test_random_texts();

    release_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_out.size() != 0)
      report_mismatch("results never delivered", 32'h0, 32'(predicted_out.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
